// ----- rtl/pli_pkg.sv -----
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package pli_pkg;

    localparam int ACTION_W     = 2;
    localparam int POS_W        = 7;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_DUMP   = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

endpackage

// ----- rtl/pli_req_if.sv -----
// Request channel: action, position and value with valid/ready.
`timescale 1ns / 1ps

interface pli_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [pli_pkg::ACTION_W-1:0]          action;
    logic [pli_pkg::POS_W-1:0]             position;
    logic signed [pli_pkg::VALUE_W-1:0]    value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);
endinterface

// ----- rtl/pli_res_if.sv -----
// Result channel: status, value, count and last flag with valid/ready.
`timescale 1ns / 1ps

interface pli_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [pli_pkg::STATUS_W-1:0]          status;
    logic signed [pli_pkg::VALUE_W-1:0]    value_res;
    logic [pli_pkg::COUNT_W-1:0]           count;
    logic                                  last;

    modport source (output valid, status, value_res, count, last, input ready);
    modport sink   (input valid, status, value_res, count, last, output ready);
endinterface

// ----- rtl/positional_list_insert_delete.sv -----
// Positional list engine: ordered list in a single-port-write RAM with shift by RMW.
//
//   channel | dir | payload                          | handshake
//   --------+-----+----------------------------------+-------------------------
//   i_req   | in  | action, position, value          | valid & ready, sink
//   o_res   | out | status, value_res, count, last   | valid & ready, source
//
// One request at a time; i_req.ready is high only while the engine is idle.
// Insert at position p over n entries moves L = n-p+1 entries: pipelined
// shift-up reads (one RAM read and one write per cycle), a write of the last
// moved entry when L > 0, a write of the new value into its slot, then the
// result is loaded. Delete: L = n-p+1 reads, a drain step, a closing step,
// then the result is loaded.
// Refused requests and an empty dump go straight to loading the result.
// Dump: one result per cycle while o_res.ready is high; a stalled output
// holds the pipeline (the RAM read data is held).
// Reset (synchronous, active low) empties the list; RAM contents are kept and
// never read beyond the current count, so no clearing pass is needed.
// A finished result waits in the output register while the next request is
// taken in.
`timescale 1ns / 1ps

module positional_list_insert_delete #(
    parameter int CAPACITY = pli_pkg::DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pli_req_if.sink   i_req,
    pli_res_if.source o_res
);
    import pli_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    // compare width: holds the position and count + 1
    localparam int CMPW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DOWN,
        S_DUMP,
        S_RESP
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;

    // list storage
    logic [VALUE_W-1:0]   r_mem [CAPACITY];
    logic [VALUE_W-1:0]   r_rdata;

    // sequencer
    logic [AW-1:0]        r_ptr;      // next read address
    logic [AW-1:0]        r_waddr;    // write target for pending read data
    logic [AW-1:0]        r_k;        // insert slot
    logic [CW-1:0]        r_left;     // reads still to issue
    logic                 r_pend;     // r_rdata valid for the sequencer
    logic                 r_pfirst;   // pending data is the deleted entry
    logic                 r_plast;    // pending data is the final dump entry
    logic                 r_first;    // next read is the first one
    logic [VALUE_W-1:0]   r_val;      // value to insert
    t_status              r_st;
    logic [VALUE_W-1:0]   r_rv;

    // output register
    logic                 r_ov;
    t_status              r_o_status;
    logic [VALUE_W-1:0]   r_o_value;
    logic [COUNT_W-1:0]   r_o_count;
    logic                 r_o_last;

    logic                 out_free;
    logic                 issue;
    logic                 dump_load;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [VALUE_W-1:0]   mem_wdata;
    logic [CMPW-1:0]      pos_ext;
    logic [CMPW-1:0]      cnt_ext;
    logic [CMPW-1:0]      k_ext;
    logic                 ins_bad;
    logic                 del_bad;
    logic                 is_full;

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_ov;
    assign o_res.status    = r_o_status;
    assign o_res.value_res = r_o_value;
    assign o_res.count     = r_o_count;
    assign o_res.last      = r_o_last;

    assign out_free = !r_ov || o_res.ready;

    // position checks
    always_comb begin
        pos_ext = CMPW'(i_req.position);
        cnt_ext = CMPW'(r_count);
        k_ext   = pos_ext - CMPW'(1);
        ins_bad = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
        del_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
        is_full = (cnt_ext == CMPW'(CAPACITY));
    end

    // RAM port control
    always_comb begin
        issue     = 1'b0;
        dump_load = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = r_rdata;
        case (r_state)
            S_UP: begin
                issue = (r_left != '0);
                if (r_pend) begin
                    mem_we = 1'b1;
                end else if (r_left == '0) begin
                    // shift done: drop the new value into its slot
                    mem_we    = 1'b1;
                    mem_waddr = r_k;
                    mem_wdata = r_val;
                end
            end
            S_DOWN: begin
                issue  = (r_left != '0);
                mem_we = r_pend && !r_pfirst;
            end
            S_DUMP: begin
                dump_load = r_pend && out_free;
                issue     = (r_left != '0) && (!r_pend || out_free);
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end

            if (issue) begin
                r_left   <= r_left - CW'(1);
                r_first  <= 1'b0;
                r_pfirst <= r_first;
                r_plast  <= (r_left == CW'(1));
                if (r_state == S_UP) begin
                    r_ptr   <= r_ptr - AW'(1);
                    r_waddr <= r_ptr + AW'(1);
                end else begin
                    r_ptr   <= r_ptr + AW'(1);
                    r_waddr <= r_ptr - AW'(1);
                end
            end

            case (r_state)
                S_UP, S_DOWN: r_pend <= issue;
                S_DUMP:       r_pend <= issue || (r_pend && !dump_load);
                default:      r_pend <= 1'b0;
            endcase

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_val   <= i_req.value;
                        r_rv    <= '0;
                        r_first <= 1'b1;
                        case (i_req.action)
                            ACT_INSERT: begin
                                if (ins_bad) begin
                                    r_st    <= ST_BADPOS;
                                    r_state <= S_RESP;
                                end else if (is_full) begin
                                    r_st    <= ST_FULL;
                                    r_state <= S_RESP;
                                end else begin
                                    r_k     <= k_ext[AW-1:0];
                                    r_ptr   <= AW'(r_count - CW'(1));
                                    r_left  <= CW'(cnt_ext - k_ext);
                                    r_state <= S_UP;
                                end
                            end
                            ACT_DELETE: begin
                                if (del_bad) begin
                                    r_st    <= ST_BADPOS;
                                    r_state <= S_RESP;
                                end else begin
                                    r_ptr   <= k_ext[AW-1:0];
                                    r_left  <= CW'(cnt_ext - k_ext);
                                    r_state <= S_DOWN;
                                end
                            end
                            ACT_DUMP: begin
                                if (r_count == '0) begin
                                    r_st    <= ST_EMPTY;
                                    r_state <= S_RESP;
                                end else begin
                                    r_ptr   <= '0;
                                    r_left  <= r_count;
                                    r_state <= S_DUMP;
                                end
                            end
                            default: begin
                                // unused action code
                                r_st    <= ST_BADPOS;
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_UP: begin
                    if (r_left == '0 && !r_pend) begin
                        r_count <= r_count + CW'(1);
                        r_st    <= ST_OK;
                        r_state <= S_RESP;
                    end
                end
                S_DOWN: begin
                    if (r_pend && r_pfirst) begin
                        r_rv <= r_rdata;
                    end
                    if (r_left == '0 && !r_pend) begin
                        r_count <= r_count - CW'(1);
                        r_st    <= ST_OK;
                        r_state <= S_RESP;
                    end
                end
                S_DUMP: begin
                    if (dump_load) begin
                        r_ov       <= 1'b1;
                        r_o_status <= ST_OK;
                        r_o_value  <= r_rdata;
                        r_o_count  <= COUNT_W'(r_count);
                        r_o_last   <= r_plast;
                        if (r_plast) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_st;
                        r_o_value  <= r_rv;
                        r_o_count  <= COUNT_W'(r_count);
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the positional list engine: directed and random requests.
`timescale 1ns / 1ps

module testbench;
    import pli_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;

    // Action code the block does not define; it answers with a bad-position status.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Quiet cycles after the last expected result: a full shift pass and some margin.
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

    // One expected result, at the widths of the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value_res;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pli_req_if req_if ();
    pli_res_if res_if ();

    positional_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    // Shadow of the list contents, front of the list at index 0.
    logic signed [VALUE_W-1:0] list_shadow[$];
    // Results owed by the block, oldest first.
    t_list_result              expected_results[$];

    int mismatch_count  = 0;
    // Percent of cycles the request side idles and the result side stalls.
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void push_expected(logic [STATUS_W-1:0] status,
                                          logic signed [VALUE_W-1:0] value_res,
                                          int count, logic last);
        t_list_result r;
        r.status    = status;
        r.value_res = value_res;
        r.count     = count[COUNT_W-1:0];
        r.last      = last;
        expected_results.push_back(r);
    endfunction

    // Applies one accepted request to the shadow list and queues what it owes.
    function automatic void predict_list_op(logic [ACTION_W-1:0] act,
                                            logic [POS_W-1:0] pos,
                                            logic signed [VALUE_W-1:0] val);
        int                        n;
        int                        p;
        logic signed [VALUE_W-1:0] removed;
        n = list_shadow.size();
        p = int'(pos);
        case (act)
            ACT_INSERT: begin
                // Position check wins over the full check.
                if (p < 1 || p > n + 1) begin
                    push_expected(ST_BADPOS, '0, n, 1'b1);
                end else if (n >= CAPACITY) begin
                    push_expected(ST_FULL, '0, n, 1'b1);
                end else begin
                    list_shadow.insert(p - 1, val);
                    push_expected(ST_OK, '0, n + 1, 1'b1);
                end
            end
            ACT_DELETE: begin
                if (p < 1 || p > n) begin
                    push_expected(ST_BADPOS, '0, n, 1'b1);
                end else begin
                    removed = list_shadow[p - 1];
                    list_shadow.delete(p - 1);
                    push_expected(ST_OK, removed, n - 1, 1'b1);
                end
            end
            ACT_DUMP: begin
                if (n == 0) begin
                    push_expected(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        push_expected(ST_OK, list_shadow[i], n, i == n - 1);
                end
            end
            default: begin
                push_expected(ST_BADPOS, '0, n, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%08h, want 0x%08h", name, got, want));
    endtask

    // Outputs and ready are sampled at the edge, before any update made at it.
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(res_if.status), 32'(want.status));
                check_field("value_res", res_if.value_res, want.value_res);
                check_field("count", 32'(res_if.count), 32'(want.count));
                check_field("last", 32'(res_if.last), 32'(want.last));
            end
        end
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // Sends one request; returns once it has been accepted and predicted.
    // valid gets one assignment per edge, so back-to-back requests hold it high.
    task automatic issue_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                 logic signed [VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid    <= 1'b0;
            req_if.value    <= $urandom;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.action   <= act;
        req_if.position <= pos;
        req_if.value    <= val;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1)
            @(posedge i_clk);
        predict_list_op(act, pos, val);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes, each action, and every refused case but a full list, on a short list.
    task automatic test_directed();
        issue_request(ACT_DUMP, 7'd0, '0);                    // empty dump
        issue_request(ACT_DELETE, 7'd1, '0);                  // delete from empty
        issue_request(ACT_DELETE, 7'd0, 32'sh7FFF_FFFF);      // position zero
        issue_request(ACT_INSERT, 7'd0, 32'sh1234_5678);      // position zero
        issue_request(ACT_INSERT, 7'd2, 32'sh1234_5678);      // past count+1
        issue_request(ACT_INSERT, 7'd1, 32'sh7FFF_FFFF);      // most positive
        issue_request(ACT_INSERT, 7'd2, 32'sh8000_0000);      // append, most negative
        issue_request(ACT_INSERT, 7'd1, -32'sd1);             // front
        issue_request(ACT_INSERT, 7'd2, 32'sd0);              // middle
        issue_request(ACT_INSERT, 7'd65, 32'sh0F0F_0F0F);     // highest position a full list accepts
        issue_request(ACT_UNUSED, 7'd1, 32'shDEAD_BEEF);      // undefined action
        issue_request(ACT_DUMP, 7'd64, '0);
        issue_request(ACT_DELETE, 7'd5, '0);                  // one past count
        issue_request(ACT_DELETE, 7'd4, '0);                  // tail
        issue_request(ACT_DELETE, 7'd2, '0);                  // middle
        issue_request(ACT_DELETE, 7'd1, '0);                  // head
        issue_request(ACT_DUMP, 7'd0, '0);
        issue_request(ACT_DELETE, 7'd1, '0);                  // back to empty
        issue_request(ACT_DUMP, 7'd0, '0);
        issue_request(ACT_INSERT, 7'd1, 32'sh5555_5555);
        issue_request(ACT_INSERT, 7'd1, 32'shAAAA_AAAA);
        issue_request(ACT_UNUSED, 7'd64, -32'sd1);
        issue_request(ACT_DUMP, 7'd0, '0);
    endtask

    // Fills the list at random positions, then hits the full case and
    // a complete 64-entry dump (count and positions with their top bit set).
    task automatic test_fill_to_capacity();
        while (list_shadow.size() < CAPACITY)
            issue_request(ACT_INSERT, POS_W'($urandom_range(1, list_shadow.size() + 1)),
                          $urandom);
        issue_request(ACT_INSERT, 7'd65, $urandom);           // legal position, full
        issue_request(ACT_INSERT, 7'd1, $urandom);            // legal position, full
        issue_request(ACT_INSERT, 7'd0, $urandom);            // bad position beats full
        issue_request(ACT_DUMP, 7'd0, '0);
        issue_request(ACT_DELETE, 7'd65, '0);                 // one past count
        issue_request(ACT_DELETE, 7'd64, '0);
        issue_request(ACT_DELETE, 7'd1, '0);
        issue_request(ACT_DUMP, 7'd0, '0);
    endtask

    // Mostly legal inserts and deletes with random content, some dumps,
    // and a share of refused requests.
    task automatic test_random_ops(int n_ops);
        int                        roll;
        int                        n;
        int                        insert_share;
        logic [ACTION_W-1:0]       act;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] val;
        for (int k = 0; k < n_ops; k++) begin
            roll = $urandom_range(0, 99);
            n    = list_shadow.size();
            val  = $urandom;
            // Keep the list mid-sized so dumps stay short.
            insert_share = (n < 24) ? 50 : 25;
            if (roll < 12) begin
                case ($urandom_range(0, 3))
                    0: begin
                        act = ACT_INSERT;
                        pos = (n + 2 <= 65) ? POS_W'($urandom_range(n + 2, 65)) : '0;
                    end
                    1: begin
                        act = ACT_DELETE;
                        pos = POS_W'($urandom_range(n + 1, 65));
                    end
                    2: begin
                        act = $urandom_range(0, 1) ? ACT_INSERT : ACT_DELETE;
                        pos = '0;
                    end
                    default: begin
                        act = ACT_UNUSED;
                        pos = POS_W'($urandom_range(0, 65));
                    end
                endcase
            end else if (roll < 22) begin
                act = ACT_DUMP;
                pos = POS_W'($urandom_range(0, 65));
            end else if (roll < 22 + insert_share) begin
                act = ACT_INSERT;
                pos = POS_W'($urandom_range(1, n + 1));
            end else begin
                act = ACT_DELETE;
                pos = (n > 0) ? POS_W'($urandom_range(1, n)) : 7'd1;
            end
            issue_request(act, pos, val);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.action   = ACT_INSERT;
        req_if.position = '0;
        req_if.value    = '0;
        res_if.ready    = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Light request gaps, heavy result stalls.
        set_idling(10, 80);
        test_directed();
        test_random_ops(35);

        // Heavy request gaps, light result stalls.
        set_idling(80, 10);
        test_fill_to_capacity();
        test_random_ops(30);

        // Full rate both ways.
        set_idling(0, 0);
        test_random_ops(35);

        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        // Anything the block emits now is flagged by the checker.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
